>>> rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the block transfer sequencer
// Action codes, sequencer states, address unit controls and helper functions.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int LIST_W     = 16;
  localparam int REG_W      = 4;
  localparam int ADDR_W     = 32;
  localparam int BYTES_W    = 7;
  localparam int CNT_W      = 5;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  localparam logic [BYTES_W-1:0] EMPTY_LIST_BYTES = 7'd64;
  localparam logic [LIST_W-1:0]  PC_ONLY_LIST     = 16'h8000;
  localparam logic [REG_W-1:0]   PC_REG           = 4'd15;
  localparam logic [ADDR_W-1:0]  WORD_BYTES       = 32'd4;

  typedef enum logic [2:0] {
    ACT_ADVANCE_PC  = 3'd0,
    ACT_WRITEBACK   = 3'd1,
    ACT_TRANSFER    = 3'd2,
    ACT_RESTORE     = 3'd3,
    ACT_FLUSH       = 3'd4,
    ACT_FLUSH_XCHG  = 3'd5,
    ACT_FLUSH_PLAIN = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_INIT,
    ST_RUN
  } seq_state_t;

  typedef enum logic [1:0] {
    AOP_BASE,
    AOP_FIRST,
    AOP_STEP
  } addr_op_t;

  typedef struct packed {
    addr_op_t op;
    logic     increment;
    logic     pre_index;
  } addr_ctl_t;

  // Count the listed registers.
  function automatic logic [CNT_W-1:0] popcount(input logic [LIST_W-1:0] list);
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < LIST_W; i++) begin
      cnt = cnt + CNT_W'(list[i]);
    end
    return cnt;
  endfunction

  // Number of the lowest listed register.
  function automatic logic [REG_W-1:0] lowest_reg(input logic [LIST_W-1:0] list);
    logic [REG_W-1:0] idx;
    idx = '0;
    for (int i = LIST_W - 1; i >= 0; i--) begin
      if (list[i]) begin
        idx = REG_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/block_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// block_transfer_sequencer: multiple-register load/store address sequencer
// Expands one decoded block transfer into its ordered run of actions.
// ----------------------------------------------------------------------------
// A run holds 1 to 19 actions. An instruction is accepted, then the new base
// and the first address are formed in turn in a single shared 32-bit adder,
// then the run issues one action per cycle while the output side does not
// stall, each word address stepped by that same adder. The input is ready
// again as soon as the last action of a run sits in the output register. The
// v5_rules register is taken at each instruction's acceptance and is written
// through the cfg channel, which is always ready.
module block_transfer_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,       // v5_rules
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // register_list[15:0], base_reg[19:16], base_value[51:20], increment[52],
  // pre_index[53], is_load[54], base_update[55], s_bit[56], zero[63:57]
  input  logic [bts_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // action[2:0], reg_index[6:3], addr_or_value[38:7], xfer_load[39],
  // user_bank[40], zero[47:41]
  output logic [bts_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast    // last
);

  logic                         v5_rules;
  bts_pkg::action_t             action;
  logic [bts_pkg::REG_W-1:0]    reg_index;
  logic [bts_pkg::ADDR_W-1:0]   addr_or_value;
  logic                         xfer_load;
  logic                         user_bank;

  assign cfg_ready = 1'b1;

  // Hold the rule select
  always_ff @(posedge clk) begin
    if (rst) begin
      v5_rules <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      v5_rules <= cfg_data;
    end
  end

  bts_sequencer u_sequencer (
    .clk           (clk),
    .rst           (rst),
    .v5_rules      (v5_rules),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .register_list (s_axis_tdata[15:0]),
    .base_reg      (s_axis_tdata[19:16]),
    .base_value    (s_axis_tdata[51:20]),
    .increment     (s_axis_tdata[52]),
    .pre_index     (s_axis_tdata[53]),
    .is_load       (s_axis_tdata[54]),
    .base_update   (s_axis_tdata[55]),
    .s_bit         (s_axis_tdata[56]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .action        (action),
    .reg_index     (reg_index),
    .addr_or_value (addr_or_value),
    .xfer_load     (xfer_load),
    .user_bank     (user_bank),
    .last          (m_axis_tlast)
  );

  // Pack the result fields
  assign m_axis_tdata = {7'd0, user_bank, xfer_load, addr_or_value, reg_index, action};

endmodule

>>> rtl/bts_addr_unit.sv
// ----------------------------------------------------------------------------
// bts_addr_unit: shared address adder
// One 32-bit add/subtract used for the new base, the first address and
// every address step of a block transfer.
// ----------------------------------------------------------------------------
module bts_addr_unit (
  input  bts_pkg::addr_ctl_t                ctl,
  input  logic [bts_pkg::ADDR_W-1:0]        base_value,
  input  logic [bts_pkg::BYTES_W-1:0]       bytes,
  input  logic [bts_pkg::ADDR_W-1:0]        new_base,
  input  logic [bts_pkg::ADDR_W-1:0]        addr,
  output logic [bts_pkg::ADDR_W-1:0]        result
);

  logic [bts_pkg::ADDR_W-1:0] opa;
  logic [bts_pkg::ADDR_W-1:0] opb;
  logic                       sub;

  // Pick operands for the current step
  always_comb begin
    opa = addr;
    opb = bts_pkg::WORD_BYTES;
    sub = 1'b0;
    unique case (ctl.op)
      bts_pkg::AOP_BASE: begin
        opa = base_value;
        opb = {{(bts_pkg::ADDR_W - bts_pkg::BYTES_W){1'b0}}, bytes};
        sub = !ctl.increment;
      end
      bts_pkg::AOP_FIRST: begin
        // lowest address of the block, stepped by one word when pre_index
        // equals increment
        opa = ctl.increment ? base_value : new_base;
        opb = (ctl.pre_index == ctl.increment) ? bts_pkg::WORD_BYTES : '0;
      end
      bts_pkg::AOP_STEP: begin
        opa = addr;
        opb = bts_pkg::WORD_BYTES;
      end
      default: begin
        opa = addr;
        opb = bts_pkg::WORD_BYTES;
      end
    endcase
  end

  // Add, or subtract through the inverted operand and carry in
  assign result = opa + (opb ^ {bts_pkg::ADDR_W{sub}}) + {{(bts_pkg::ADDR_W-1){1'b0}}, sub};

endmodule

>>> rtl/bts_sequencer.sv
// ----------------------------------------------------------------------------
// bts_sequencer: action sequencer
// Decodes one block transfer, drives the shared address unit and issues the
// run of actions into an output register, one per cycle while the output does not stall.
// ----------------------------------------------------------------------------
module bts_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              v5_rules,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bts_pkg::LIST_W-1:0]        register_list,
  input  logic [bts_pkg::REG_W-1:0]         base_reg,
  input  logic [bts_pkg::ADDR_W-1:0]        base_value,
  input  logic                              increment,
  input  logic                              pre_index,
  input  logic                              is_load,
  input  logic                              base_update,
  input  logic                              s_bit,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bts_pkg::action_t                  action,
  output logic [bts_pkg::REG_W-1:0]         reg_index,
  output logic [bts_pkg::ADDR_W-1:0]        addr_or_value,
  output logic                              xfer_load,
  output logic                              user_bank,
  output logic                              last
);

  bts_pkg::seq_state_t state, state_next;

  // held instruction
  logic [bts_pkg::LIST_W-1:0]  list, list_next;
  logic [bts_pkg::REG_W-1:0]   base;
  logic [bts_pkg::ADDR_W-1:0]  bval;
  logic [bts_pkg::BYTES_W-1:0] bytes;
  logic                        inc, pre, ld, ub;
  bts_pkg::action_t            flush_kind;
  logic [bts_pkg::ADDR_W-1:0]  new_base;
  logic [bts_pkg::ADDR_W-1:0]  addr;
  logic                        p_pc, p_early, p_sr, p_late, p_flush;

  // decode of the incoming item
  logic                        empty, first, lastb, single, pc_load_in, early, late;
  logic [bts_pkg::LIST_W-1:0]  eff_list, low_mask;
  logic [bts_pkg::BYTES_W-1:0] bytes_in;
  bts_pkg::action_t            kind_in;

  // shared unit
  bts_pkg::addr_ctl_t          actl;
  logic [bts_pkg::ADDR_W-1:0]  sum;

  // output stage
  logic                        out_load, emit, rest;
  bts_pkg::action_t            act_n;
  logic [bts_pkg::REG_W-1:0]   reg_n;
  logic [bts_pkg::ADDR_W-1:0]  val_n;
  logic                        ld_n, ub_n;
  logic                        p_pc_next, p_early_next, p_sr_next, p_late_next, p_flush_next;

  assign in_ready = (state == bts_pkg::ST_IDLE);
  assign out_load = !out_valid || out_ready;

  // Decode the instruction at acceptance
  always_comb begin
    empty      = (register_list == '0);
    eff_list   = (empty && !v5_rules) ? bts_pkg::PC_ONLY_LIST : register_list;
    low_mask   = (bts_pkg::LIST_W'(1) << base_reg) - bts_pkg::LIST_W'(1);
    first      = !empty && ((register_list & low_mask) == '0);
    lastb      = !empty && ((register_list >> base_reg) == bts_pkg::LIST_W'(1));
    single     = (register_list == (bts_pkg::LIST_W'(1) << base_reg));
    pc_load_in = is_load && eff_list[bts_pkg::PC_REG];
    early      = base_update && !is_load && !v5_rules && !first;
    if (is_load) begin
      late = v5_rules ? (!lastb || single) : !eff_list[base_reg];
    end else begin
      late = !early;
    end
    bytes_in = empty ? bts_pkg::EMPTY_LIST_BYTES
                     : {bts_pkg::popcount(register_list), 2'b00};
    if (s_bit) begin
      kind_in = bts_pkg::ACT_FLUSH;
    end else if (v5_rules) begin
      kind_in = bts_pkg::ACT_FLUSH_XCHG;
    end else begin
      kind_in = bts_pkg::ACT_FLUSH_PLAIN;
    end
  end

  // Drive the shared address unit by state
  always_comb begin
    actl.increment = inc;
    actl.pre_index = pre;
    unique case (state)
      bts_pkg::ST_CALC: actl.op = bts_pkg::AOP_BASE;
      bts_pkg::ST_INIT: actl.op = bts_pkg::AOP_FIRST;
      default:          actl.op = bts_pkg::AOP_STEP;
    endcase
  end

  bts_addr_unit u_addr_unit (
    .ctl        (actl),
    .base_value (bval),
    .bytes      (bytes),
    .new_base   (new_base),
    .addr       (addr),
    .result     (sum)
  );

  // Next state and the next action of the run
  always_comb begin
    state_next   = state;
    list_next    = list;
    p_pc_next    = p_pc;
    p_early_next = p_early;
    p_sr_next    = p_sr;
    p_late_next  = p_late;
    p_flush_next = p_flush;
    act_n        = bts_pkg::ACT_ADVANCE_PC;
    reg_n        = '0;
    val_n        = '0;
    ld_n         = 1'b0;
    ub_n         = 1'b0;
    rest         = 1'b0;
    emit         = 1'b0;
    unique case (state)
      bts_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = bts_pkg::ST_CALC;
        end
      end
      bts_pkg::ST_CALC: begin
        state_next = bts_pkg::ST_INIT;
      end
      bts_pkg::ST_INIT: begin
        state_next = bts_pkg::ST_RUN;
      end
      bts_pkg::ST_RUN: begin
        emit = out_load;
        if (p_pc) begin
          p_pc_next = 1'b0;
          rest      = p_early || (|list) || p_sr || p_late || p_flush;
        end else if (p_early) begin
          act_n        = bts_pkg::ACT_WRITEBACK;
          reg_n        = base;
          val_n        = new_base;
          p_early_next = 1'b0;
          rest         = (|list) || p_sr || p_late || p_flush;
        end else if (|list) begin
          act_n     = bts_pkg::ACT_TRANSFER;
          reg_n     = bts_pkg::lowest_reg(list);
          val_n     = addr;
          ld_n      = ld;
          ub_n      = ub;
          list_next = list & (list - bts_pkg::LIST_W'(1));
          rest      = (|list_next) || p_sr || p_late || p_flush;
        end else if (p_sr) begin
          act_n     = bts_pkg::ACT_RESTORE;
          p_sr_next = 1'b0;
          rest      = p_late || p_flush;
        end else if (p_late) begin
          act_n       = bts_pkg::ACT_WRITEBACK;
          reg_n       = base;
          val_n       = new_base;
          p_late_next = 1'b0;
          rest        = p_flush;
        end else begin
          act_n        = flush_kind;
          p_flush_next = 1'b0;
          rest         = 1'b0;
        end
        if (out_load && !rest) begin
          state_next = bts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bts_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bts_pkg::ST_IDLE;
      out_valid <= 1'b0;
      p_pc      <= 1'b0;
      p_early   <= 1'b0;
      p_sr      <= 1'b0;
      p_late    <= 1'b0;
      p_flush   <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        p_pc    <= !pc_load_in;
        p_early <= early;
        p_sr    <= s_bit && pc_load_in;
        p_late  <= base_update && late;
        p_flush <= pc_load_in;
      end else if (emit) begin
        p_pc    <= p_pc_next;
        p_early <= p_early_next;
        p_sr    <= p_sr_next;
        p_late  <= p_late_next;
        p_flush <= p_flush_next;
      end
    end
  end

  // Instruction, address and output payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      list       <= eff_list;
      base       <= base_reg;
      bval       <= base_value;
      bytes      <= bytes_in;
      inc        <= increment;
      pre        <= pre_index;
      ld         <= is_load;
      ub         <= s_bit && !pc_load_in;
      flush_kind <= kind_in;
    end else if (emit) begin
      list <= list_next;
    end
    if (state == bts_pkg::ST_CALC) begin
      new_base <= sum;
    end
    // load the first address, then step it once per word moved
    if (state == bts_pkg::ST_INIT || (emit && act_n == bts_pkg::ACT_TRANSFER)) begin
      addr <= sum;
    end
    if (emit) begin
      action        <= act_n;
      reg_index     <= reg_n;
      addr_or_value <= val_n;
      xfer_load     <= ld_n;
      user_bank     <= ub_n;
      last          <= !rest;
    end
  end

endmodule

>>> rtl/bts_checker.sv
// ----------------------------------------------------------------------------
// bts_checker: port-level checks of the block transfer sequencer
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module bts_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [bts_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                m_axis_tlast
);

  logic                       busy;
  logic                       seen_xfer;
  logic [bts_pkg::REG_W-1:0]  prev_reg;
  logic                       s_xfer, m_xfer, is_word, is_side;

  assign s_xfer  = s_axis_tvalid && s_axis_tready;
  assign m_xfer  = m_axis_tvalid && m_axis_tready;
  assign is_word = (m_axis_tdata[2:0] == bts_pkg::ACT_TRANSFER);
  assign is_side = (m_axis_tdata[2:0] != bts_pkg::ACT_TRANSFER)
                && (m_axis_tdata[2:0] != bts_pkg::ACT_WRITEBACK);

  // Track a run from acceptance until its last action shows up
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      seen_xfer <= 1'b0;
    end else begin
      if (s_xfer) begin
        busy <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tlast) begin
        busy <= 1'b0;
      end
      if (m_xfer && m_axis_tlast) begin
        seen_xfer <= 1'b0;
      end else if (m_xfer && is_word) begin
        seen_xfer <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_xfer && is_word) begin
      prev_reg <= m_axis_tdata[6:3];
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_one_run: assert property (@(posedge clk) disable iff (rst)
    s_xfer |-> !busy || (m_axis_tvalid && m_axis_tlast))
    else $error("instruction accepted while a run is still being issued");

  a_side_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && is_side |->
      m_axis_tdata[bts_pkg::OUT_DATA_W-1:3] == '0)
    else $error("non-transfer action carries register or address");

  a_reg_order: assert property (@(posedge clk) disable iff (rst)
    m_xfer && is_word && seen_xfer |-> m_axis_tdata[6:3] > prev_reg)
    else $error("word transfers out of register order");

endmodule

bind block_transfer_sequencer bts_checker u_bts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
